// ===== rtl/core/pcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbs_pkg: shared types and constants
// Pixel, configuration and square-root pipeline types, luma weights and
// register index codes for the contrast, brightness and saturation adjuster.
// ----------------------------------------------------------------------------
package pcbs_pkg;

   localparam int CHAN_W = 8;
   localparam int NUM_CH = 3;

   // Configuration register widths.
   localparam int FACTOR_W = 18;
   localparam int OFFSET_W = 9;
   localparam int GAIN_W   = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 18;

   // Square-root pipeline: a 32-bit radicand gives a 16-bit root, two
   // root bits are resolved in each register stage.
   localparam int RAD_W       = 32;
   localparam int ROOT_W      = 16;
   localparam int REM_W       = 18;
   localparam int SQRT_STEPS  = 2;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

   // Perceived brightness weights in Q16 for red, green and blue.
   localparam int LUMA_W = 16;
   localparam logic [LUMA_W-1:0] LUMA_WEIGHT [NUM_CH] = '{16'd19595, 16'd38470, 16'd7471};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CONTRAST,
      REG_BRIGHTNESS,
      REG_SATURATION
   } reg_index_type;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [NUM_CH-1:0] pix_type;   // index 0 red, 1 green, 2 blue

   typedef struct packed {
      logic        [FACTOR_W-1:0] contrast_factor;
      logic signed [OFFSET_W-1:0] brightness_offset;
      logic        [GAIN_W-1:0]   saturation_gain;
   } cfg_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;    // radicand bits not yet brought down, MSB first
      logic [REM_W-1:0]  rem;    // partial remainder
      logic [ROOT_W-1:0] root;   // partial root
      pix_type           pix;    // adjusted pixel carried alongside
   } sqrt_state_type;

endpackage

// ===== rtl/core/pcbs_color.sv =====
// ----------------------------------------------------------------------------
// pcbs_color: contrast and brightness
// Two register stages: contrast product, then truncation, offset and clamping.
// ----------------------------------------------------------------------------
module pcbs_color (
   input  logic              clock,
   input  logic              reset,
   input  pcbs_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  pcbs_pkg::pix_type in_pix,
   output logic              out_valid,
   input  logic              out_ready,
   output pcbs_pkg::pix_type out_pix
);

   logic [1:0] valid_ff, valid_in;
   logic [1:0] stg_ready;

   logic signed [27:0] prod_ff [pcbs_pkg::NUM_CH];
   logic signed [27:0] prod_in [pcbs_pkg::NUM_CH];
   pcbs_pkg::pix_type  pix_ff, pix_in;

   logic signed [8:0]  delta     [pcbs_pkg::NUM_CH];
   logic signed [27:0] shifted   [pcbs_pkg::NUM_CH];
   logic [7:0]         contrasted[pcbs_pkg::NUM_CH];
   logic signed [9:0]  bright    [pcbs_pkg::NUM_CH];

   assign stg_ready[1] = !valid_ff[1] || out_ready;
   assign stg_ready[0] = !valid_ff[0] || stg_ready[1];
   assign in_ready     = stg_ready[0];

   assign valid_in[0] = stg_ready[0] ? in_valid    : valid_ff[0];
   assign valid_in[1] = stg_ready[1] ? valid_ff[0] : valid_ff[1];

   always_comb begin
      for (int i = 0; i < pcbs_pkg::NUM_CH; i++) begin
         // Distance from mid gray, then the Q10.8 factor applied to it.
         delta[i]   = $signed({1'b0, in_pix[i]}) - 9'sd128;
         prod_in[i] = $signed({1'b0, cfg.contrast_factor}) * delta[i];

         // Add mid gray back in Q.8, drop the fraction and clamp.
         shifted[i] = prod_ff[i] + 28'sd32768;
         if (shifted[i][27]) begin
            contrasted[i] = 8'd0;
         end else if (|shifted[i][27:16]) begin
            contrasted[i] = 8'd255;
         end else begin
            contrasted[i] = shifted[i][15:8];
         end

         bright[i] = $signed({2'b00, contrasted[i]}) + 10'(cfg.brightness_offset);
         if (bright[i][9]) begin
            pix_in[i] = 8'd0;
         end else if (bright[i][8]) begin
            pix_in[i] = 8'd255;
         end else begin
            pix_in[i] = bright[i][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 2'b00;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[0]) begin
         prod_ff <= prod_in;
      end
      if (stg_ready[1]) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_pix   = pix_ff;

endmodule

// ===== rtl/core/pcbs_luma.sv =====
// ----------------------------------------------------------------------------
// pcbs_luma: weighted sum of squares
// Three register stages: channel squares, Q16 weighting, and the sum that
// seeds the square-root pipeline.
// ----------------------------------------------------------------------------
module pcbs_luma (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pcbs_pkg::pix_type        in_pix,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pcbs_pkg::sqrt_state_type out_state
);

   logic [2:0] valid_ff, valid_in;
   logic [2:0] stg_ready;

   logic [15:0] sq_ff [pcbs_pkg::NUM_CH];
   logic [15:0] sq_in [pcbs_pkg::NUM_CH];
   logic [31:0] wt_ff [pcbs_pkg::NUM_CH];
   logic [31:0] wt_in [pcbs_pkg::NUM_CH];
   logic [pcbs_pkg::RAD_W-1:0] sum_ff, sum_in;
   pcbs_pkg::pix_type pix_a_ff, pix_b_ff, pix_c_ff;

   assign stg_ready[2] = !valid_ff[2] || out_ready;
   assign stg_ready[1] = !valid_ff[1] || stg_ready[2];
   assign stg_ready[0] = !valid_ff[0] || stg_ready[1];
   assign in_ready     = stg_ready[0];

   assign valid_in[0] = stg_ready[0] ? in_valid    : valid_ff[0];
   assign valid_in[1] = stg_ready[1] ? valid_ff[0] : valid_ff[1];
   assign valid_in[2] = stg_ready[2] ? valid_ff[1] : valid_ff[2];

   always_comb begin
      for (int i = 0; i < pcbs_pkg::NUM_CH; i++) begin
         sq_in[i] = in_pix[i] * in_pix[i];
         wt_in[i] = sq_ff[i] * pcbs_pkg::LUMA_WEIGHT[i];
      end
   end

   // The weights sum to 65536, so the total stays below 2^32.
   assign sum_in = wt_ff[0] + wt_ff[1] + wt_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 3'b000;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[0]) begin
         sq_ff    <= sq_in;
         pix_a_ff <= in_pix;
      end
      if (stg_ready[1]) begin
         wt_ff    <= wt_in;
         pix_b_ff <= pix_a_ff;
      end
      if (stg_ready[2]) begin
         sum_ff   <= sum_in;
         pix_c_ff <= pix_b_ff;
      end
   end

   assign out_valid      = valid_ff[2];
   assign out_state.rad  = sum_ff;
   assign out_state.rem  = '0;
   assign out_state.root = '0;
   assign out_state.pix  = pix_c_ff;

endmodule

// ===== rtl/core/pcbs_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// pcbs_sqrt_stage: one stage of the integer square root
// Resolves two root bits by restoring digit recurrence and registers the
// partial remainder, partial root and the pixel that travels with them.
// ----------------------------------------------------------------------------
module pcbs_sqrt_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pcbs_pkg::sqrt_state_type in_state,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pcbs_pkg::sqrt_state_type out_state
);

   logic valid_ff, valid_in;
   pcbs_pkg::sqrt_state_type state_ff, state_in;

   logic [pcbs_pkg::REM_W+1:0] partial [pcbs_pkg::SQRT_STEPS];
   logic [pcbs_pkg::REM_W+1:0] trial   [pcbs_pkg::SQRT_STEPS];
   pcbs_pkg::sqrt_state_type   step    [pcbs_pkg::SQRT_STEPS+1];

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      step[0] = in_state;
      for (int k = 0; k < pcbs_pkg::SQRT_STEPS; k++) begin
         // Bring down the next two radicand bits and try root*4+1.
         partial[k]   = {step[k].rem, step[k].rad[pcbs_pkg::RAD_W-1 -: 2]};
         trial[k]     = {2'b00, step[k].root, 2'b01};
         step[k+1]     = step[k];
         step[k+1].rad = {step[k].rad[pcbs_pkg::RAD_W-3:0], 2'b00};
         if (partial[k] >= trial[k]) begin
            step[k+1].rem  = pcbs_pkg::REM_W'(partial[k] - trial[k]);
            step[k+1].root = {step[k].root[pcbs_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            step[k+1].rem  = partial[k][pcbs_pkg::REM_W-1:0];
            step[k+1].root = {step[k].root[pcbs_pkg::ROOT_W-2:0], 1'b0};
         end
      end
      state_in = step[pcbs_pkg::SQRT_STEPS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== rtl/core/pcbs_sat.sv =====
// ----------------------------------------------------------------------------
// pcbs_sat: saturation
// Two register stages: gain product around the perceived brightness, then
// the final sum, truncation and clamping into the output register.
// ----------------------------------------------------------------------------
module pcbs_sat (
   input  logic                     clock,
   input  logic                     reset,
   input  pcbs_pkg::cfg_type        cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pcbs_pkg::sqrt_state_type in_state,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pcbs_pkg::pix_type        out_pix
);

   logic [1:0] valid_ff, valid_in;
   logic [1:0] stg_ready;

   logic signed [17:0] diff    [pcbs_pkg::NUM_CH];
   logic signed [34:0] prod_ff [pcbs_pkg::NUM_CH];
   logic signed [34:0] prod_in [pcbs_pkg::NUM_CH];
   logic [pcbs_pkg::ROOT_W-1:0] luma_ff;
   logic signed [35:0] total   [pcbs_pkg::NUM_CH];
   pcbs_pkg::pix_type  pix_ff, pix_in;

   assign stg_ready[1] = !valid_ff[1] || out_ready;
   assign stg_ready[0] = !valid_ff[0] || stg_ready[1];
   assign in_ready     = stg_ready[0];

   assign valid_in[0] = stg_ready[0] ? in_valid    : valid_ff[0];
   assign valid_in[1] = stg_ready[1] ? valid_ff[0] : valid_ff[1];

   always_comb begin
      for (int i = 0; i < pcbs_pkg::NUM_CH; i++) begin
         // Channel minus perceived brightness, both in Q8, times the Q8.8 gain.
         diff[i]    = $signed({2'b00, in_state.pix[i], 8'h00})
                    - $signed({2'b00, in_state.root});
         prod_in[i] = diff[i] * $signed({1'b0, cfg.saturation_gain});

         total[i] = $signed({12'h000, luma_ff, 8'h00}) + 36'(prod_ff[i]);
         if (total[i][35]) begin
            pix_in[i] = 8'd0;
         end else if (|total[i][35:24]) begin
            pix_in[i] = 8'd255;
         end else begin
            pix_in[i] = total[i][23:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 2'b00;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[0]) begin
         prod_ff <= prod_in;
         luma_ff <= in_state.root;
      end
      if (stg_ready[1]) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_pix   = pix_ff;

endmodule

// ===== rtl/core/pixel_contrast_brightness_saturation.sv =====
// ----------------------------------------------------------------------------
// pixel_contrast_brightness_saturation: RGB pixel adjuster
// Applies contrast, brightness and saturation: one pixel per clock if unstalled.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                       Direction  Moves
//  req       req_valid/ready, req_{red,green,blue}_in    in         one pixel
//  rsp       rsp_valid/ready, rsp_{red,green,blue}_out   out        one pixel
//  csr       csr_valid/ready, csr_index, csr_data        in         one register
//
// One request is taken per clock unless the response side stalls. Its path
// runs through 2 stages of contrast and brightness, 3 of weighted squares, 8
// of square root (two root bits per stage) and 2 of saturation, the last one
// being the output register. Every stage holds its own valid bit and advances
// whenever the stage after it is empty or moving, so a stalled response
// closes up bubbles behind it and nothing is dropped or repeated. A
// synchronous reset empties the pipeline and restores the unity settings.
//
// Register map (csr_index): contrast factor (unsigned Q10.8), brightness
// offset (signed, 9 bits), saturation gain (unsigned Q8.8). Writes to an
// unused index are ignored. The user must write registers only while the
// pipeline is idle, as the block does not enforce it; csr_ready is always high.
//
module pixel_contrast_brightness_saturation (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pcbs_pkg::CHAN_W-1:0]         req_red_in,
   input  logic [pcbs_pkg::CHAN_W-1:0]         req_green_in,
   input  logic [pcbs_pkg::CHAN_W-1:0]         req_blue_in,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pcbs_pkg::CHAN_W-1:0]         rsp_red_out,
   output logic [pcbs_pkg::CHAN_W-1:0]         rsp_green_out,
   output logic [pcbs_pkg::CHAN_W-1:0]         rsp_blue_out,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pcbs_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Configuration registers. The reset values leave every pixel unchanged.
   pcbs_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pcbs_pkg::REG_CONTRAST: begin
               cfg_in.contrast_factor = csr_data[pcbs_pkg::FACTOR_W-1:0];
            end
            pcbs_pkg::REG_BRIGHTNESS: begin
               cfg_in.brightness_offset = $signed(csr_data[pcbs_pkg::OFFSET_W-1:0]);
            end
            pcbs_pkg::REG_SATURATION: begin
               cfg_in.saturation_gain = csr_data[pcbs_pkg::GAIN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.contrast_factor   <= pcbs_pkg::FACTOR_W'(256);
         cfg_ff.brightness_offset <= '0;
         cfg_ff.saturation_gain   <= pcbs_pkg::GAIN_W'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request pixel, channel 0 is red.
   pcbs_pkg::pix_type req_pix;
   assign req_pix[0] = req_red_in;
   assign req_pix[1] = req_green_in;
   assign req_pix[2] = req_blue_in;

   // Contrast and brightness.
   logic              color_valid, color_ready;
   pcbs_pkg::pix_type color_pix;

   pcbs_color u_color (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pix    (req_pix),
      .out_valid (color_valid),
      .out_ready (color_ready),
      .out_pix   (color_pix)
   );

   // Weighted sum of squares, which seeds the square-root chain.
   logic                     sq_valid [pcbs_pkg::SQRT_STAGES+1];
   logic                     sq_ready [pcbs_pkg::SQRT_STAGES+1];
   pcbs_pkg::sqrt_state_type sq_state [pcbs_pkg::SQRT_STAGES+1];

   pcbs_luma u_luma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (color_valid),
      .in_ready  (color_ready),
      .in_pix    (color_pix),
      .out_valid (sq_valid[0]),
      .out_ready (sq_ready[0]),
      .out_state (sq_state[0])
   );

   // Perceived brightness in Q8: floor of the square root of the Q16 sum.
   for (genvar s = 0; s < pcbs_pkg::SQRT_STAGES; s++) begin : g_sqrt
      pcbs_sqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[s]),
         .in_ready  (sq_ready[s]),
         .in_state  (sq_state[s]),
         .out_valid (sq_valid[s+1]),
         .out_ready (sq_ready[s+1]),
         .out_state (sq_state[s+1])
      );
   end

   // Saturation and the output register.
   pcbs_pkg::pix_type rsp_pix;

   pcbs_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (sq_valid[pcbs_pkg::SQRT_STAGES]),
      .in_ready  (sq_ready[pcbs_pkg::SQRT_STAGES]),
      .in_state  (sq_state[pcbs_pkg::SQRT_STAGES]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pix   (rsp_pix)
   );

   assign rsp_red_out   = rsp_pix[0];
   assign rsp_green_out = rsp_pix[1];
   assign rsp_blue_out  = rsp_pix[2];

endmodule
